[design/pisq_pkg.sv]
`timescale 1ns / 1ps

package pisq_pkg;

  // Field widths.
  localparam int ADC_W    = 10;
  localparam int GAIN_W   = 16;
  localparam int PERIOD_W = 16;
  localparam int DUTY_W   = 16;
  localparam int LOG_IDX_W = 8;
  localparam int INTEG_W  = 32;
  localparam int ERR_W    = ADC_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_LOW    = 3'd4;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd3999;
  localparam logic [ADC_W-1:0]    REF_HIGH_RST   = 10'd800;
  localparam logic [ADC_W-1:0]    REF_LOW_RST    = 10'd200;

  // Default block parameters.
  localparam int WAVE_PERIOD_DEF    = 1000;
  localparam int CAPTURE_POINTS_DEF = 200;
  localparam int DECIMATE_BY_DEF    = 10;

  // Shared multiplier operand widths and product width.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Percent in Q.12: effort is clamped to 0..PCT_FULL after adding PCT_OFFSET.
  localparam int U_W    = 19;
  localparam int USUM_W = 50;
  localparam logic signed [USUM_W-1:0] PCT_OFFSET = 50'sd204800;
  localparam logic signed [USUM_W-1:0] PCT_FULL   = 50'sd409600;

  // Scaled product is shifted by 12 and divided by 100 through a reciprocal.
  localparam int Y_W    = 23;
  localparam int Q_W    = 17;
  localparam int RECIP_SHIFT = 30;
  localparam logic signed [MUL_B_W-1:0] RECIP_M = 25'sd10737418;
  localparam logic [Y_W:0] DIV_C = 24'd100;

  // Multiplier operand selection.
  localparam logic [1:0] MUL_KP    = 2'd0;
  localparam logic [1:0] MUL_KI    = 2'd1;
  localparam logic [1:0] MUL_SCALE = 2'd2;
  localparam logic [1:0] MUL_RECIP = 2'd3;

  typedef struct packed {
    logic       in_ready;
    logic       accept;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       save_p1;
    logic       save_u;
    logic       save_y;
    logic       load_out;
  } pisq_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic out_ready;
  } pisq_sts_t;

endpackage

[design/pisq_if.sv]
`timescale 1ns / 1ps

interface pisq_in_if;
  import pisq_pkg::*;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] adc_sample;
  logic             start_capture;

  modport source (output valid, output adc_sample, output start_capture, input ready);
  modport sink   (input valid, input adc_sample, input start_capture, output ready);
endinterface

interface pisq_out_if;
  import pisq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DUTY_W-1:0]    duty_compare;
  logic [ADC_W-1:0]     reference_now;
  logic                 log_valid;
  logic [LOG_IDX_W-1:0] log_index;
  logic [ADC_W-1:0]     log_adc;
  logic [ADC_W-1:0]     log_ref;
  logic                 capture_done;

  modport source (output valid, output duty_compare, output reference_now, output log_valid,
                  output log_index, output log_adc, output log_ref, output capture_done,
                  input ready);
  modport sink   (input valid, input duty_compare, input reference_now, input log_valid,
                  input log_index, input log_adc, input log_ref, input capture_done,
                  output ready);
endinterface

interface pisq_cfg_if;
  import pisq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/pisq_ctrl.sv]
`timescale 1ns / 1ps

module pisq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pisq_pkg::pisq_sts_t   sts,
  output pisq_pkg::pisq_cmd_t   cmd
);
  import pisq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_P1    = 3'd1;
  localparam logic [2:0] ST_P2    = 3'd2;
  localparam logic [2:0] ST_SUM   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_RECIP = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.mul_sel = MUL_KP;
    case (state_r)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = ST_P1;
        end
      end
      ST_P1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_KP;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_KI;
        cmd.save_p1 = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.save_u = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_SCALE;
        state_nxt = ST_RECIP;
      end
      ST_RECIP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MUL_RECIP;
        cmd.save_y = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Wait here while the previous result still sits unread.
        if (!sts.out_full || sts.out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/pisq_dp.sv]
`timescale 1ns / 1ps

module pisq_dp #(
  parameter int WAVE_PERIOD    = pisq_pkg::WAVE_PERIOD_DEF,
  parameter int CAPTURE_POINTS = pisq_pkg::CAPTURE_POINTS_DEF,
  parameter int DECIMATE_BY    = pisq_pkg::DECIMATE_BY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  pisq_in_if.sink             in_ch,
  pisq_out_if.source          out_ch,
  pisq_cfg_if.sink            cfg_ch,
  input  pisq_pkg::pisq_cmd_t cmd,
  output pisq_pkg::pisq_sts_t sts
);
  import pisq_pkg::*;

  localparam int WW = $clog2(WAVE_PERIOD);
  localparam int DW = $clog2(DECIMATE_BY + 1);
  localparam logic [WW-1:0] WAVE_HALF = WW'(WAVE_PERIOD / 2);
  localparam logic [WW-1:0] WAVE_LAST = WW'(WAVE_PERIOD - 1);
  localparam logic [DW-1:0] DEC_LAST  = DW'(DECIMATE_BY - 1);
  localparam logic [LOG_IDX_W-1:0] CAP_LAST = LOG_IDX_W'(CAPTURE_POINTS - 1);

  // Configuration registers.
  logic signed [GAIN_W-1:0] kp_r;
  logic signed [GAIN_W-1:0] ki_r;
  logic [PERIOD_W-1:0]      period_r;
  logic [ADC_W-1:0]         ref_high_r;
  logic [ADC_W-1:0]         ref_low_r;

  // Loop and capture state.
  logic [WW-1:0]                 wave_r, wave_nxt;
  logic signed [INTEG_W-1:0]     integ_r, integ_nxt;
  logic [DW-1:0]                 dec_r, dec_nxt;
  logic [LOG_IDX_W-1:0]          cap_pos_r, cap_pos_nxt;
  logic                          capturing_r, capturing_nxt;

  // Per-item working registers.
  logic signed [ERR_W-1:0]  err_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] p1_r;
  logic [U_W-1:0]           u_r;
  logic [Y_W-1:0]           y_r;
  logic [ADC_W-1:0]         refv_r;
  logic                     lv_r;
  logic [LOG_IDX_W-1:0]     li_r;
  logic [ADC_W-1:0]         la_r;
  logic [ADC_W-1:0]         lr_r;
  logic                     done_r;

  // Output register.
  logic                 out_valid_r;
  logic [DUTY_W-1:0]    duty_r;
  logic [ADC_W-1:0]     o_ref_r;
  logic                 o_lv_r;
  logic [LOG_IDX_W-1:0] o_li_r;
  logic [ADC_W-1:0]     o_la_r;
  logic [ADC_W-1:0]     o_lr_r;
  logic                 o_done_r;

  // Accept-cycle combinational values.
  logic [ADC_W-1:0]         refv;
  logic signed [ERR_W-1:0]  err;
  logic signed [INTEG_W:0]  integ_sum;
  logic                     arm;
  logic                     cap_on;
  logic [DW-1:0]            dec_base;
  logic [LOG_IDX_W-1:0]     pos_base;
  logic                     hit;
  logic                     last_pt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [USUM_W-1:0]  u_sum;
  logic [U_W-1:0]            u_clamp;
  logic [Q_W-1:0]            q0;
  logic [Y_W:0]              q100;
  logic [Y_W:0]              rem;
  logic [Q_W-1:0]            quot;

  assign in_ch.ready  = cmd.in_ready;
  assign cfg_ch.ready = 1'b1;

  assign sts.in_valid  = in_ch.valid;
  assign sts.out_full  = out_valid_r;
  assign sts.out_ready = out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      period_r   <= PWM_PERIOD_RST;
      ref_high_r <= REF_HIGH_RST;
      ref_low_r  <= REF_LOW_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_KP_GAIN:    kp_r       <= cfg_ch.data;
        CFG_KI_GAIN:    ki_r       <= cfg_ch.data;
        CFG_PWM_PERIOD: period_r   <= cfg_ch.data;
        CFG_REF_HIGH:   ref_high_r <= cfg_ch.data[ADC_W-1:0];
        CFG_REF_LOW:    ref_low_r  <= cfg_ch.data[ADC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    refv = (wave_r < WAVE_HALF) ? ref_high_r : ref_low_r;
    err = $signed({1'b0, refv}) - $signed({1'b0, in_ch.adc_sample});
    integ_sum = {integ_r[INTEG_W-1], integ_r} + (INTEG_W + 1)'(err);

    // The two top bits disagree exactly when the 32-bit sum overflowed.
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_nxt = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_sum[INTEG_W-1:0];
    end

    // A request starts a run on this very item.
    arm = in_ch.start_capture && !capturing_r;
    cap_on = capturing_r || arm;
    dec_base = arm ? '0 : dec_r;
    pos_base = arm ? '0 : cap_pos_r;
    hit = cap_on && (dec_base == DEC_LAST);
    last_pt = hit && (pos_base == CAP_LAST);

    wave_nxt = (wave_r == WAVE_LAST) ? '0 : wave_r + 1'b1;
    dec_nxt = cap_on ? (hit ? '0 : dec_base + 1'b1) : dec_r;
    if (last_pt) begin
      cap_pos_nxt = '0;
    end else if (hit) begin
      cap_pos_nxt = pos_base + 1'b1;
    end else begin
      cap_pos_nxt = pos_base;
    end
    capturing_nxt = cap_on && !last_pt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r      <= '0;
      integ_r     <= '0;
      dec_r       <= '0;
      cap_pos_r   <= '0;
      capturing_r <= 1'b0;
    end else if (cmd.accept) begin
      wave_r      <= wave_nxt;
      integ_r     <= integ_nxt;
      dec_r       <= dec_nxt;
      cap_pos_r   <= cap_pos_nxt;
      capturing_r <= capturing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r  <= err;
      refv_r <= refv;
      lv_r   <= hit;
      li_r   <= hit ? pos_base : '0;
      la_r   <= hit ? in_ch.adc_sample : '0;
      lr_r   <= hit ? refv : '0;
      done_r <= last_pt;
    end
  end

  // One shared multiplier serves both gains, the duty scaling and the
  // reciprocal division by 100.
  always_comb begin
    case (cmd.mul_sel)
      MUL_KP: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(kp_r);
      end
      MUL_KI: begin
        mul_a = MUL_A_W'(integ_r);
        mul_b = MUL_B_W'(ki_r);
      end
      MUL_SCALE: begin
        mul_a = $signed({{(MUL_A_W-U_W){1'b0}}, u_r});
        mul_b = $signed({{(MUL_B_W-PERIOD_W){1'b0}}, period_r});
      end
      MUL_RECIP: begin
        mul_a = $signed({{(MUL_A_W-Y_W){1'b0}}, prod_r[Y_W+11:12]});
        mul_b = RECIP_M;
      end
      default: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(kp_r);
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    u_sum = $signed(p1_r[USUM_W-1:0]) + $signed(prod_r[USUM_W-1:0]) + PCT_OFFSET;
    if (u_sum[USUM_W-1]) begin
      u_clamp = '0;
    end else if (u_sum > PCT_FULL) begin
      u_clamp = PCT_FULL[U_W-1:0];
    end else begin
      u_clamp = u_sum[U_W-1:0];
    end

    // The reciprocal estimate is low by at most one.
    q0 = prod_r[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
    q100 = (Y_W + 1)'(q0) * DIV_C;
    rem = {1'b0, y_r} - q100;
    quot = (rem >= DIV_C) ? q0 + 1'b1 : q0;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.save_p1) begin
      p1_r <= prod_r;
    end
    if (cmd.save_u) begin
      u_r <= u_clamp;
    end
    if (cmd.save_y) begin
      y_r <= prod_r[Y_W+11:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      duty_r   <= quot[DUTY_W-1:0];
      o_ref_r  <= refv_r;
      o_lv_r   <= lv_r;
      o_li_r   <= li_r;
      o_la_r   <= la_r;
      o_lr_r   <= lr_r;
      o_done_r <= done_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_compare  = duty_r;
  assign out_ch.reference_now = o_ref_r;
  assign out_ch.log_valid     = o_lv_r;
  assign out_ch.log_index     = o_li_r;
  assign out_ch.log_adc       = o_la_r;
  assign out_ch.log_ref       = o_lr_r;
  assign out_ch.capture_done  = o_done_r;

endmodule

[design/pi_loop_square_reference_pwm.sv]
`timescale 1ns / 1ps

// PI loop with a square-wave reference and PWM duty output. Each input item is
// one control tick: the block picks the reference level from its wave counter,
// updates a saturating 32-bit error integrator, forms Kp*e + Ki*integral in
// Q.12 percent, offsets by 50 percent, clamps to 0..100 percent and scales it to
// a compare value of the PWM period, truncating. A capture request logs every
// DECIMATE_BY-th tick for CAPTURE_POINTS points. An item walks the states P1,
// P2, SUM, SCALE, RECIP and OUT after acceptance, and no new item is taken
// before OUT loads its result; the pace is set by the single shared multiplier,
// which is used in four passes per item (proportional, integral, duty scaling
// and division by 100 through a reciprocal). The result waits in an output
// register, and the next item is accepted while it waits. Gains and references
// are written through the configuration port, which is always ready.
module pi_loop_square_reference_pwm #(
  parameter int WAVE_PERIOD    = pisq_pkg::WAVE_PERIOD_DEF,
  parameter int CAPTURE_POINTS = pisq_pkg::CAPTURE_POINTS_DEF,
  parameter int DECIMATE_BY    = pisq_pkg::DECIMATE_BY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pisq_in_if.sink    in_ch,
  pisq_out_if.source out_ch,
  pisq_cfg_if.sink   cfg_ch
);
  import pisq_pkg::*;

  pisq_cmd_t cmd;
  pisq_sts_t sts;

  pisq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  pisq_dp #(
    .WAVE_PERIOD    (WAVE_PERIOD),
    .CAPTURE_POINTS (CAPTURE_POINTS),
    .DECIMATE_BY    (DECIMATE_BY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

  // Only one item is in flight, so acceptance drops ready for the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an item is still in work");

  a_done_is_logged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.capture_done) |-> out_ch.log_valid)
    else $error("capture done without a logged point");

  a_log_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.log_valid) |->
      (out_ch.log_index == '0 && out_ch.log_adc == '0 && out_ch.log_ref == '0))
    else $error("log fields set on a tick that is not logged");

  a_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_ch.valid)
    else $error("result load did not raise output valid");

endmodule

[verif/pi_loop_square_reference_pwm_tb.sv]
`timescale 1ns / 1ps

module pi_loop_square_reference_pwm_tb;
  import pisq_pkg::*;

  localparam int HALF_WAVE    = WAVE_PERIOD_DEF / 2;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASES       = 12;
  localparam int PHASE_TICKS  = 78;
  localparam int MAX_PRINTS   = 40;
  localparam int DIRECTED_N   = 16;
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_REF_LOW + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX  = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [ADC_W-1:0] adc;
    logic             arm;
  } tick_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]    duty;
    logic [ADC_W-1:0]     level;
    logic                 log_valid;
    logic [LOG_IDX_W-1:0] log_index;
    logic [ADC_W-1:0]     log_adc;
    logic [ADC_W-1:0]     log_ref;
    logic                 done;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst_n;

  pisq_in_if  in_ch();
  pisq_out_if out_ch();
  pisq_cfg_if cfg_ch();

  pi_loop_square_reference_pwm dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Register copies and loop state of the controller.
  logic signed [GAIN_W-1:0] kp_q = '0;
  logic signed [GAIN_W-1:0] ki_q = '0;
  logic [PERIOD_W-1:0]      period_q = PWM_PERIOD_RST;
  logic [ADC_W-1:0]         ref_high_q = REF_HIGH_RST;
  logic [ADC_W-1:0]         ref_low_q = REF_LOW_RST;
  int                       wave_pos = 0;
  int                       integ_q = 0;
  int                       dec_cnt = 0;
  int                       cap_pos = 0;
  bit                       capturing = 1'b0;

  tick_in_t   tick_backlog[$];
  tick_out_t  tick_results[$];
  tick_in_t   next_tick;
  tick_out_t  got_tick;
  idle_mode_e idle_mode = IDLE_NONE;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         pushed_cnt = 0;
  int         checked_cnt = 0;
  int         errors = 0;
  int         quiet_cycles = 0;

  int directed_adc[DIRECTED_N] = '{0, 1023, 800, 799, 801, 512, 682, 341,
                                   1023, 0, 1, 1022, 600, 400, 200, 300};
  bit directed_arm[DIRECTED_N] = '{0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0};

  function automatic void run_control_tick(input logic [ADC_W-1:0] sample, input logic arm);
    tick_out_t r;
    longint    err;
    longint    acc;
    longint    effort;
    r = '0;
    r.level = (wave_pos < HALF_WAVE) ? ref_high_q : ref_low_q;
    err = longint'(r.level) - longint'(sample);
    acc = longint'(integ_q) + err;
    if (acc > INTEG_MAX) acc = INTEG_MAX;
    if (acc < INTEG_MIN) acc = INTEG_MIN;
    integ_q = int'(acc);

    effort = longint'(kp_q) * err + longint'(ki_q) * longint'(integ_q) + longint'(PCT_OFFSET);
    if (effort > longint'(PCT_FULL)) effort = longint'(PCT_FULL);
    if (effort < 0) effort = 0;
    r.duty = DUTY_W'((effort * longint'(period_q)) / longint'(PCT_FULL));

    // A request only arms a run when none is active; the arming tick counts.
    if (arm && !capturing) begin
      capturing = 1'b1;
      dec_cnt = 0;
      cap_pos = 0;
    end
    if (capturing) begin
      dec_cnt++;
      if (dec_cnt >= DECIMATE_BY_DEF) begin
        dec_cnt = 0;
        r.log_valid = 1'b1;
        r.log_index = cap_pos[LOG_IDX_W-1:0];
        r.log_adc = sample;
        r.log_ref = r.level;
        if (cap_pos + 1 >= CAPTURE_POINTS_DEF) begin
          cap_pos = 0;
          capturing = 1'b0;
          r.done = 1'b1;
        end else begin
          cap_pos++;
        end
      end
    end
    wave_pos = (wave_pos + 1 >= WAVE_PERIOD_DEF) ? 0 : wave_pos + 1;
    tick_results.push_back(r);
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic push_tick(input int adc, input bit arm);
    tick_in_t t;
    t.adc = adc[ADC_W-1:0];
    t.arm = arm;
    tick_backlog.push_back(t);
    pushed_cnt++;
  endtask

  task automatic wait_drain();
    while (checked_cnt != pushed_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_KP_GAIN:    kp_q = val;
      CFG_KI_GAIN:    ki_q = val;
      CFG_PWM_PERIOD: period_q = val;
      CFG_REF_HIGH:   ref_high_q = val[ADC_W-1:0];
      CFG_REF_LOW:    ref_low_q = val[ADC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int kp, input int ki, input int period, input int rh,
                           input int rl);
    write_reg(CFG_KP_GAIN, kp[GAIN_W-1:0]);
    write_reg(CFG_KI_GAIN, ki[GAIN_W-1:0]);
    write_reg(CFG_PWM_PERIOD, period[PERIOD_W-1:0]);
    write_reg(CFG_REF_HIGH, CFG_DATA_W'(rh[ADC_W-1:0]));
    write_reg(CFG_REF_LOW, CFG_DATA_W'(rl[ADC_W-1:0]));
  endtask

  // Input driver: a new item is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.adc_sample    <= '0;
      in_ch.start_capture <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        run_control_tick(in_ch.adc_sample, in_ch.start_capture);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tick_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tick = tick_backlog.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.adc_sample    <= next_tick.adc;
          in_ch.start_capture <= next_tick.arm;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tick_results.size() == 0) begin
          flag_mismatch("result with no tick outstanding");
        end else begin
          got_tick = tick_results.pop_front();
          check_field("duty_compare", out_ch.duty_compare, got_tick.duty);
          check_field("reference_now", out_ch.reference_now, got_tick.level);
          check_field("log_valid", out_ch.log_valid, got_tick.log_valid);
          check_field("log_index", out_ch.log_index, got_tick.log_index);
          check_field("log_adc", out_ch.log_adc, got_tick.log_adc);
          check_field("log_ref", out_ch.log_ref, got_tick.log_ref);
          check_field("capture_done", out_ch.capture_done, got_tick.done);
          checked_cnt++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pi_loop_square_reference_pwm_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int adc;
    int lvl;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A few ticks on the register reset values.
    push_tick(0, 1'b0);
    push_tick(1023, 1'b0);
    push_tick(800, 1'b0);
    push_tick(200, 1'b0);
    wait_drain();

    // Directed ticks, including an arm request while a run is already active.
    write_all(2048, 4, 1000, 800, 200);
    for (int i = 0; i < DIRECTED_N; i++) push_tick(directed_adc[i], directed_arm[i]);
    wait_drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      idle_mode = idle_mode_e'(phase % 4);
      send_idle_pct  = (idle_mode == IDLE_SENDER) ? 46 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      recv_stall_pct = (idle_mode == IDLE_RECEIVER) ? 46 : (idle_mode == IDLE_BOTH) ? 7 : 0;
      case (phase)
        0: write_all(4096, 16, 1000, 800, 200);
        1: write_all(-32768, 32767, 65535, 1023, 0);
        // A zero period register must give a zero compare value.
        2: write_all(32767, -32768, 0, 0, 1023);
        3: begin
          write_all(1, 1, 1, 512, 511);
          write_reg(CFG_UNUSED_IDX, 16'hFFFF);
          write_reg(CFG_SPARE_IDX, 16'hA5A5);
        end
        default: begin
          if (phase % 2 == 0) begin
            write_all($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(1023), $urandom_range(1023));
          end else begin
            write_all(int'($urandom_range(2000)) - 1000, int'($urandom_range(8)) - 4,
                      $urandom_range(1, 8000), $urandom_range(1023), $urandom_range(1023));
          end
        end
      endcase

      for (int n = 0; n < PHASE_TICKS; n++) begin
        case ($urandom_range(9))
          0: adc = 0;
          1: adc = 1023;
          2, 3, 4, 5: adc = $urandom_range(1023);
          default: begin
            lvl = $urandom_range(1) ? int'(ref_high_q) : int'(ref_low_q);
            adc = lvl + int'($urandom_range(62)) - 31;
            if (adc < 0) adc = 0;
            if (adc > 1023) adc = 1023;
          end
        endcase
        push_tick(adc, $urandom_range(39) == 0);
      end
      wait_drain();
    end

    if (tick_results.size() != 0) flag_mismatch("ticks left without a result");
    if (errors == 0) begin
      $display("pi_loop_square_reference_pwm_tb OK");
    end else begin
      $display("pi_loop_square_reference_pwm_tb NOT OK");
    end
    $finish;
  end

endmodule
